// File: design/eog_blink_segmenter_defines.svh
// Assertion macros shared by the blink segmenter RTL.
// Depends on nothing; included by files that carry assertions.
`ifndef EOG_BLINK_SEGMENTER_DEFINES_SVH
`define EOG_BLINK_SEGMENTER_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define EBS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: check failed");
// Next-cycle implication checked outside reset.
`define EBS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: check failed");
`endif

// File: design/ebs_pkg.sv
// Shared types and constants of the blink segmenter.
// No dependencies.
package ebs_pkg;
  localparam int unsigned LineW = 17;
  typedef enum logic [1:0] {
    RegThreshold = 2'd0,
    RegTolerance = 2'd1,
    RegHalfWin   = 2'd2,
    RegSkip      = 2'd3
  } reg_idx_e;
  localparam logic KindBlink   = 1'b0;
  localparam logic KindSummary = 1'b1;
endpackage

// File: design/ebs_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module ebs_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// File: design/eog_blink_segmenter.sv
// Top level of the EOG blink segmenter: capture, end-of-run scan, reports.
// Depends on ebs_pkg, ebs_ram and eog_blink_segmenter_defines.svh.
//
// Usage: samples enter on the input channel (sample_i, last_i, valid/stall).
// While storing, one sample is accepted per cycle; the first skip_count
// samples of a run are discarded and the rest go into a sample RAM of
// MAX_SAMPLES entries. A sample with last_i set starts the scan, during which
// the input is stalled. The scan reads the RAM one entry at a time and waits
// for the registered read data of each entry before it issues the next read;
// the peak test, the half-window search and the edge walks all read this way.
// Each blink gives one report item (kind 0) up to MAX_BLINK_REPORTS, after
// which the scan ends with overflow set; a summary item (kind 1,
// final_res 1) always closes the run. Results wait in an output register:
// while the receiver stalls, the scan holds. Reset clears all control state
// and the run statistics; configuration takes the reset values. RAM contents
// are not cleared, since the scan reads only entries written in this run.
// Configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i.
`include "eog_blink_segmenter_defines.svh"
module eog_blink_segmenter import ebs_pkg::*; #(
  parameter int unsigned MAX_SAMPLES       = 4096,
  parameter int unsigned MAX_BLINK_REPORTS = 63,
  parameter int unsigned SAMPLE_BITS       = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_idx_i,
  input  logic [15:0]            cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  logic                   last_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   kind_o,
  output logic [16:0]            blink_start_o,
  output logic [16:0]            blink_end_o,
  output logic [16:0]            blink_peak_line_o,
  output logic [15:0]            blink_peak_value_o,
  output logic [14:0]            pos_max_value_o,
  output logic [16:0]            pos_max_line_o,
  output logic [15:0]            neg_max_value_o,
  output logic [16:0]            neg_max_line_o,
  output logic                   overflow_o,
  output logic                   final_res_o
);
  localparam int unsigned AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int unsigned CW = $clog2(MAX_SAMPLES + 1);
  // Index width with room for signed window arithmetic.
  localparam int unsigned IW = CW + 2;
  localparam int unsigned RW = $clog2(MAX_BLINK_REPORTS + 1);
  localparam int unsigned MW = SAMPLE_BITS;  // magnitude fits unsigned

  typedef enum logic [3:0] {
    StCapture, StPrep, StTest, StSrch, StAdj, StWalkS, StWalkE,
    StEmit, StSummary, StWait
  } state_e;

  // Configuration registers.
  logic [14:0] thr_q, tol_q;
  logic [9:0]  hw_q;
  logic [15:0] skip_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= '0;
      tol_q  <= 15'd400;
      hw_q   <= 10'd64;
      skip_q <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        RegThreshold: thr_q  <= cfg_data_i[14:0];
        RegTolerance: tol_q  <= cfg_data_i[14:0];
        RegHalfWin:   hw_q   <= cfg_data_i[9:0];
        RegSkip:      skip_q <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  state_e state_q;
  logic [CW-1:0] cnt_q;
  logic [15:0] skipped_q;
  logic signed [SAMPLE_BITS-1:0] pos_q, neg_q;
  logic [16:0] pos_line_q, neg_line_q;
  logic sovf_q, dropped_q;
  logic [RW-1:0] nrep_q;

  // Scan registers; phase_q picks which of the three neighbors is read.
  logic signed [IW-1:0] j_q, k_q, j1_q, j2_q, idx_q;
  logic [MW:0] best_q, td_q;
  logic [1:0] phase_q;
  logic rd_pend_q;

  logic accept_in;
  logic accept_out;
  assign accept_in  = in_valid_i && !in_stall_o;
  assign accept_out = out_valid_o && !out_stall_i;
  assign in_stall_o = (state_q != StCapture);

  // A new result item is loaded into the output register this cycle.
  logic post_item;
  assign post_item = (!out_valid_o || accept_out) &&
                     (((state_q == StEmit) && (nrep_q < RW'(MAX_BLINK_REPORTS)) &&
                       rd_pend_q) || (state_q == StSummary));

  // Sample RAM.
  logic          ram_we;
  logic [AW-1:0] ram_raddr;
  logic [SAMPLE_BITS-1:0] ram_rdata;
  logic          store_ok;
  logic signed [IW-1:0] raddr_full;

  assign store_ok = accept_in && (skipped_q >= skip_q) && (cnt_q < CW'(MAX_SAMPLES));
  assign ram_we   = store_ok;
  assign ram_raddr = raddr_full[AW-1:0];

  ebs_ram #(.Width(SAMPLE_BITS), .Depth(MAX_SAMPLES)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(cnt_q[AW-1:0]),
    .wdata_i(sample_i),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Magnitude of the read word.
  logic signed [SAMPLE_BITS-1:0] rd_s;
  logic [MW:0] rd_mag;
  assign rd_s   = ram_rdata;
  assign rd_mag = rd_s[SAMPLE_BITS-1] ? ((MW+1)'(0) - {rd_s[SAMPLE_BITS-1], rd_s})
                                       : {1'b0, rd_s};

  logic signed [IW-1:0] n_s, hw_s, last_idx;
  assign n_s      = IW'(signed'({1'b0, cnt_q}));
  assign hw_s     = IW'(signed'({1'b0, hw_q}));
  assign last_idx = n_s - IW'(1);

  logic [16:0] cur_line;
  assign cur_line = 17'(skipped_q) + 17'd1 + 17'(cnt_q);

  function automatic logic [16:0] line_f(logic [15:0] sk, logic signed [IW-1:0] ix);
    return 17'(sk) + 17'd1 + 17'(ix);
  endfunction

  // Read address chosen by state and phase.
  always_comb begin
    unique case (state_q)
      StTest:  raddr_full = (phase_q == 2'd0) ? j_q :
                            (phase_q == 2'd1) ? j_q - IW'(1) : j_q + IW'(1);
      StSrch:  raddr_full = k_q;
      StWalkS: raddr_full = j1_q;
      StWalkE: raddr_full = j2_q;
      StEmit:  raddr_full = j_q;
      default: raddr_full = '0;
    endcase
  end

  logic signed [SAMPLE_BITS-1:0] peak_val_q;

  // Main sequencer: capture, then scan one RAM read at a time.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StCapture;
      cnt_q <= '0; skipped_q <= '0; pos_q <= '0; neg_q <= '0;
      pos_line_q <= '0; neg_line_q <= '0; sovf_q <= 1'b0; dropped_q <= 1'b0;
      nrep_q <= '0; phase_q <= '0; rd_pend_q <= 1'b0;
      out_valid_o <= 1'b0;
      j_q <= '0; k_q <= '0; j1_q <= '0; j2_q <= '0; idx_q <= '0;
      best_q <= '0; td_q <= '0;
      kind_o <= 1'b0; blink_start_o <= '0; blink_end_o <= '0;
      blink_peak_line_o <= '0; blink_peak_value_o <= '0; pos_max_value_o <= '0;
      pos_max_line_o <= '0; neg_max_value_o <= '0; neg_max_line_o <= '0;
      overflow_o <= 1'b0; final_res_o <= 1'b0; peak_val_q <= '0;
    end else begin
      if (post_item) out_valid_o <= 1'b1;
      else if (accept_out) out_valid_o <= 1'b0;
      unique case (state_q)
        StCapture: if (accept_in) begin
          if (skipped_q < skip_q) skipped_q <= skipped_q + 16'd1;
          else if (store_ok) begin
            cnt_q <= cnt_q + CW'(1);
            if (signed'(sample_i) > pos_q) begin
              pos_q <= sample_i; pos_line_q <= cur_line;
            end
            if (signed'(sample_i) < neg_q) begin
              neg_q <= sample_i; neg_line_q <= cur_line;
            end
          end else sovf_q <= 1'b1;
          if (last_i) state_q <= StPrep;
        end
        StPrep: begin
          j_q <= IW'(1); phase_q <= '0; rd_pend_q <= 1'b0;
          nrep_q <= '0; dropped_q <= 1'b0;
          state_q <= StTest;
        end
        // Peak test: read j, then j-1, then j+1.
        StTest: begin
          if (j_q + IW'(1) >= n_s) state_q <= StSummary;
          else if (!rd_pend_q) rd_pend_q <= 1'b1;
          else begin
            rd_pend_q <= 1'b0;
            unique case (phase_q)
              2'd0: begin
                td_q <= rd_mag;
                if (rd_mag < (MW+1)'(thr_q)) j_q <= j_q + IW'(1);
                else phase_q <= 2'd1;
              end
              2'd1: begin
                if (td_q < rd_mag) begin j_q <= j_q + IW'(1); phase_q <= 2'd0; end
                else phase_q <= 2'd2;
              end
              default: begin
                phase_q <= 2'd0;
                if (td_q < rd_mag) j_q <= j_q + IW'(1);
                else begin
                  j1_q <= (j_q > hw_s) ? j_q - hw_s : '0;
                  j2_q <= (j_q + hw_s > last_idx) ? last_idx : j_q + hw_s;
                  k_q  <= (j_q > hw_s) ? j_q - hw_s : '0;
                  best_q <= td_q; idx_q <= j_q;
                  state_q <= StSrch;
                end
              end
            endcase
          end
        end
        // Window search for the strongest sample, later ones win ties.
        StSrch: begin
          if (!rd_pend_q) rd_pend_q <= 1'b1;
          else begin
            rd_pend_q <= 1'b0;
            if (rd_mag >= best_q) begin best_q <= rd_mag; idx_q <= k_q; end
            if (k_q >= j2_q) state_q <= StAdj;
            else k_q <= k_q + IW'(1);
          end
        end
        StAdj: begin
          if (idx_q < j_q) j1_q <= (idx_q > hw_s) ? idx_q - hw_s : '0;
          else if (idx_q > j_q) begin
            j2_q <= (idx_q + hw_s > last_idx) ? last_idx : idx_q + hw_s;
            j_q <= idx_q;
          end
          state_q <= StWalkS;
        end
        StWalkS: begin
          if (j1_q <= '0) state_q <= StWalkE;
          else if (!rd_pend_q) rd_pend_q <= 1'b1;
          else begin
            rd_pend_q <= 1'b0;
            if (rd_mag > (MW+1)'(tol_q)) j1_q <= j1_q - IW'(1);
            else state_q <= StWalkE;
          end
        end
        StWalkE: begin
          if (j2_q >= last_idx) state_q <= StEmit;
          else if (!rd_pend_q) rd_pend_q <= 1'b1;
          else begin
            rd_pend_q <= 1'b0;
            if (rd_mag > (MW+1)'(tol_q)) j2_q <= j2_q + IW'(1);
            else state_q <= StEmit;
          end
        end
        // Read the peak value and post one report, or end the scan at the report limit.
        StEmit: begin
          if (nrep_q >= RW'(MAX_BLINK_REPORTS)) begin
            dropped_q <= 1'b1; state_q <= StSummary;
          end else if (!rd_pend_q) rd_pend_q <= 1'b1;
          else if (!out_valid_o || accept_out) begin
            rd_pend_q <= 1'b0;
            kind_o <= KindBlink;
            blink_start_o <= line_f(skipped_q, j1_q);
            blink_end_o <= line_f(skipped_q, j2_q);
            blink_peak_line_o <= line_f(skipped_q, j_q);
            blink_peak_value_o <= 16'(signed'(ram_rdata));
            pos_max_value_o <= '0; pos_max_line_o <= '0;
            neg_max_value_o <= '0; neg_max_line_o <= '0;
            overflow_o <= 1'b0; final_res_o <= 1'b0;
            nrep_q <= nrep_q + RW'(1);
            j_q <= j2_q + IW'(2);
            state_q <= StTest;
          end
        end
        StSummary: if (!out_valid_o || accept_out) begin
          kind_o <= KindSummary;
          blink_start_o <= '0; blink_end_o <= '0;
          blink_peak_line_o <= '0; blink_peak_value_o <= '0;
          pos_max_value_o <= 15'(pos_q);
          pos_max_line_o <= pos_line_q;
          neg_max_value_o <= 16'(neg_q);
          neg_max_line_o <= neg_line_q;
          overflow_o <= sovf_q || dropped_q;
          final_res_o <= 1'b1;
          cnt_q <= '0; skipped_q <= '0; pos_q <= '0; neg_q <= '0;
          pos_line_q <= '0; neg_line_q <= '0; sovf_q <= 1'b0;
          state_q <= StWait;
        end
        StWait: if (accept_out) state_q <= StCapture;
        default: state_q <= StCapture;
      endcase
    end
  end

  // Checks on the sequencer.
  `EBS_ASSERT_IMP(a_no_in_while_scan, (state_q != StCapture), !accept_in)
  `EBS_ASSERT_IMP(a_summary_is_final, out_valid_o, (kind_o == final_res_o))
  `EBS_ASSERT_NEXT(a_capture_after_summary, (state_q == StWait) && accept_out,
                   (state_q == StCapture) && !out_valid_o)
  `EBS_ASSERT_IMP(a_count_bound, 1'b1, cnt_q <= CW'(MAX_SAMPLES))
endmodule
